// ===== rtl/cfr_pkg.sv =====
package cfr_pkg;

  // configuration register indexes
  localparam logic REG_RAYS_COUNT = 1'b0;
  localparam logic REG_CONE_ANGLE = 1'b1;

  // quadrant codes from the top two phase bits
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  localparam int CORDIC_STEPS = 24;
  localparam int DIV_BITS     = 32;
  localparam int SQRT_BITS    = 31;

  localparam logic signed [33:0] ONE_Q30    = 34'sd1073741824;
  localparam logic signed [33:0] CORDIC_K   = 34'sd652032874;
  localparam logic [32:0]        RAD_SCALE  = 33'd6746518852;
  localparam logic [36:0]        HALF_SCALE = 37'd667544;
  localparam logic [41:0]        GOLD_SCALE = 42'd2654435769;

  // one rotation lane of the cordic
  typedef struct packed {
    logic [15:0]        ph;
    logic [1:0]         quad;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] ang;
  } lane_t;

  // everything one request carries down the row of cells
  typedef struct packed {
    logic               vld;
    logic               oor;
    logic               one;
    logic [9:0]         idx;
    logic [10:0]        den;
    lane_t              ha;
    lane_t              az;
    logic signed [33:0] zmin;
    logic signed [33:0] cs;
    logic signed [33:0] sn;
    logic [42:0]        num;
    logic [10:0]        rem;
    logic [31:0]        quo;
    logic signed [31:0] z;
    logic [60:0]        rad;
    logic [61:0]        root;
    logic signed [63:0] px;
    logic signed [63:0] py;
  } item_t;

  function automatic logic signed [32:0] cordic_step(input int k);
    logic signed [32:0] v;
    case (k)
      0: v = 33'sd843314857;
      1: v = 33'sd497837829;
      2: v = 33'sd263043837;
      3: v = 33'sd133525158;
      4: v = 33'sd67021687;
      5: v = 33'sd33543516;
      6: v = 33'sd16775850;
      7: v = 33'sd8388437;
      8: v = 33'sd4194283;
      9: v = 33'sd2097149;
      default: v = 33'sd1 << (30 - k);
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/cfr_cordic_cell.sv =====
module cfr_cordic_cell #(
  parameter int K = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  cfr_pkg::item_t a_in,
  output cfr_pkg::item_t a_out
);

  localparam logic signed [32:0] STEP = cfr_pkg::cordic_step(K);

  cfr_pkg::item_t item_r;
  cfr_pkg::item_t item_nxt;

  function automatic cfr_pkg::lane_t rot(input cfr_pkg::lane_t a);
    cfr_pkg::lane_t     b;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    b  = a;
    dx = $signed(a.y) >>> K;
    dy = $signed(a.x) >>> K;
    if (!a.ang[32]) begin
      b.x   = a.x - dx;
      b.y   = a.y + dy;
      b.ang = a.ang - STEP;
    end else begin
      b.x   = a.x + dx;
      b.y   = a.y - dy;
      b.ang = a.ang + STEP;
    end
    return b;
  endfunction

  always_comb begin
    item_nxt    = a_in;
    item_nxt.ha = rot(a_in.ha);
    item_nxt.az = rot(a_in.az);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.vld <= 1'b0;
    end else if (en) begin
      item_r <= item_nxt;
    end
  end

  assign a_out = item_r;

endmodule

// ===== rtl/cfr_div_cell.sv =====
module cfr_div_cell #(
  parameter int J = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  cfr_pkg::item_t a_in,
  output cfr_pkg::item_t a_out
);

  localparam int B = cfr_pkg::DIV_BITS - 1 - J;

  cfr_pkg::item_t item_r;
  cfr_pkg::item_t item_nxt;
  logic [11:0]    trial;

  // one restoring step, quotient bit B
  always_comb begin
    item_nxt = a_in;
    trial    = {a_in.rem, a_in.num[B]};
    if (trial >= {1'b0, a_in.den}) begin
      item_nxt.rem    = 11'(trial - {1'b0, a_in.den});
      item_nxt.quo[B] = 1'b1;
    end else begin
      item_nxt.rem    = trial[10:0];
      item_nxt.quo[B] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.vld <= 1'b0;
    end else if (en) begin
      item_r <= item_nxt;
    end
  end

  assign a_out = item_r;

endmodule

// ===== rtl/cfr_sqrt_cell.sv =====
module cfr_sqrt_cell #(
  parameter int M = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  cfr_pkg::item_t a_in,
  output cfr_pkg::item_t a_out
);

  localparam logic [61:0] BIT = 62'(1) << (2 * M);

  cfr_pkg::item_t item_r;
  cfr_pkg::item_t item_nxt;
  logic [61:0]    trial;

  // one result bit of the digit-by-digit root
  always_comb begin
    item_nxt = a_in;
    trial    = a_in.root + BIT;
    if ({1'b0, a_in.rad} >= trial) begin
      item_nxt.rad  = 61'({1'b0, a_in.rad} - trial);
      item_nxt.root = (a_in.root >> 1) + BIT;
    end else begin
      item_nxt.root = a_in.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.vld <= 1'b0;
    end else if (en) begin
      item_r <= item_nxt;
    end
  end

  assign a_out = item_r;

endmodule

// ===== rtl/cone_fibonacci_ray_directions.sv =====
// channel | ports                                      | direction
// --------+--------------------------------------------+----------
// in      | in_valid, in_stall, in_ray_index           | request in
// out     | out_valid, out_stall, out_dir_*, out_index_* | result out
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data  | register write
//
// one request per cycle while in_stall is low; the result passes through 95 register
// stages: 24 cordic cells, 32 divider cells, 31 square root cells and eight other
// registers.
// sync reset clears the valid bits and loads rays_count 64, cone_angle 21447.
// the whole row advances unless the output holds a result under out_stall;
// in_stall is high exactly then. cfg_ready is always high.
module cone_fibonacci_ray_directions #(
  parameter int MAX_RAYS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [9:0]         in_ray_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_dir_x,
  output logic signed [15:0] out_dir_y,
  output logic signed [15:0] out_dir_z,
  output logic               out_index_out_of_range,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);

  logic [10:0] rays_count_r;
  logic [15:0] cone_angle_r;
  logic        en;

  cfr_pkg::item_t s0_r, s0_nxt;
  cfr_pkg::item_t p1_r, p1_nxt;
  cfr_pkg::item_t q_r, q_nxt;
  cfr_pkg::item_t m1_r, m1_nxt;
  cfr_pkg::item_t za_r, za_nxt;
  cfr_pkg::item_t zb_r, zb_nxt;
  cfr_pkg::item_t mu_r, mu_nxt;
  cfr_pkg::item_t cor [cfr_pkg::CORDIC_STEPS+1];
  cfr_pkg::item_t dv [cfr_pkg::DIV_BITS+1];
  cfr_pkg::item_t sq [cfr_pkg::SQRT_BITS+1];

  logic               out_valid_r;
  logic signed [15:0] out_x_r, out_y_r, out_z_r;
  logic               out_oor_r;

  logic [10:0] n_eff;
  logic [36:0] half_prod;
  logic [41:0] gold_prod;
  logic [32:0] gold_rnd;
  logic [46:0] ha_prod, az_prod;
  logic signed [34:0] dd;
  logic [31:0] d;
  logic signed [34:0] zw;
  logic signed [31:0] zc;
  logic [30:0] zabs;
  logic signed [65:0] prod_x, prod_y;
  logic signed [63:0] rx, ry, rz;
  logic signed [15:0] ox, oy, oz;

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    logic signed [15:0] r;
    if (v > 64'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -64'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  assign en        = !(out_valid_r && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rays_count_r <= 11'd64;
      cone_angle_r <= 16'd21447;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cfr_pkg::REG_RAYS_COUNT: rays_count_r <= cfg_data[10:0];
        cfr_pkg::REG_CONE_ANGLE: cone_angle_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // request capture: range check and both phases
  always_comb begin
    n_eff = (32'(rays_count_r) > 32'(MAX_RAYS)) ? 11'(MAX_RAYS) : rays_count_r;
    half_prod = 37'(cone_angle_r) * cfr_pkg::HALF_SCALE + 37'd524288;
    gold_prod = 42'(in_ray_index) * cfr_pkg::GOLD_SCALE;
    gold_rnd  = {1'b0, gold_prod[31:0]} + 33'd32768;
    s0_nxt       = '0;
    s0_nxt.vld   = in_valid;
    s0_nxt.idx   = in_ray_index;
    s0_nxt.oor   = ({1'b0, in_ray_index} >= n_eff);
    s0_nxt.den   = n_eff - 11'd1;
    s0_nxt.one   = (n_eff == 11'd1);
    s0_nxt.ha.ph = half_prod[35:20];
    s0_nxt.az.ph = gold_rnd[31:16];
  end

  // phase to radians, cordic start vector
  always_comb begin
    ha_prod      = 47'(s0_r.ha.ph[13:0]) * 47'(cfr_pkg::RAD_SCALE);
    az_prod      = 47'(s0_r.az.ph[13:0]) * 47'(cfr_pkg::RAD_SCALE);
    p1_nxt        = s0_r;
    p1_nxt.ha.quad = s0_r.ha.ph[15:14];
    p1_nxt.az.quad = s0_r.az.ph[15:14];
    p1_nxt.ha.ang = {2'b00, ha_prod[46:16]};
    p1_nxt.az.ang = {2'b00, az_prod[46:16]};
    p1_nxt.ha.x   = cfr_pkg::CORDIC_K;
    p1_nxt.az.x   = cfr_pkg::CORDIC_K;
    p1_nxt.ha.y   = '0;
    p1_nxt.az.y   = '0;
  end

  assign cor[0] = p1_r;

  for (genvar g = 0; g < cfr_pkg::CORDIC_STEPS; g++) begin : g_cor
    cfr_cordic_cell #(.K(g)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .a_in  (cor[g]),
      .a_out (cor[g+1])
    );
  end

  // quadrant fold
  always_comb begin
    q_nxt = cor[cfr_pkg::CORDIC_STEPS];
    case (q_nxt.ha.quad)
      cfr_pkg::QUAD_0: q_nxt.zmin = q_nxt.ha.x;
      cfr_pkg::QUAD_1: q_nxt.zmin = -q_nxt.ha.y;
      cfr_pkg::QUAD_2: q_nxt.zmin = -q_nxt.ha.x;
      default:         q_nxt.zmin = q_nxt.ha.y;
    endcase
    case (q_nxt.az.quad)
      cfr_pkg::QUAD_0: begin
        q_nxt.cs = q_nxt.az.x;
        q_nxt.sn = q_nxt.az.y;
      end
      cfr_pkg::QUAD_1: begin
        q_nxt.cs = -q_nxt.az.y;
        q_nxt.sn = q_nxt.az.x;
      end
      cfr_pkg::QUAD_2: begin
        q_nxt.cs = -q_nxt.az.x;
        q_nxt.sn = -q_nxt.az.y;
      end
      default: begin
        q_nxt.cs = q_nxt.az.y;
        q_nxt.sn = -q_nxt.az.x;
      end
    endcase
  end

  // height span times index, rounded numerator for the divider
  always_comb begin
    dd     = 35'(cfr_pkg::ONE_Q30) - 35'(q_r.zmin);
    d      = dd[34] ? 32'd0 : dd[31:0];
    m1_nxt = q_r;
    m1_nxt.num = 43'(d) * 43'(q_r.idx) + 43'(q_r.den >> 1);
    m1_nxt.rem = m1_nxt.num[42:32];
    m1_nxt.quo = '0;
  end

  assign dv[0] = m1_r;

  for (genvar g = 0; g < cfr_pkg::DIV_BITS; g++) begin : g_div
    cfr_div_cell #(.J(g)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .a_in  (dv[g]),
      .a_out (dv[g+1])
    );
  end

  always_comb begin
    zw = 35'(cfr_pkg::ONE_Q30) - $signed({3'b000, dv[cfr_pkg::DIV_BITS].quo});
    if (dv[cfr_pkg::DIV_BITS].one || zw > 35'(cfr_pkg::ONE_Q30)) begin
      zc = 32'(cfr_pkg::ONE_Q30);
    end else if (zw < -35'(cfr_pkg::ONE_Q30)) begin
      zc = -32'(cfr_pkg::ONE_Q30);
    end else begin
      zc = zw[31:0];
    end
    za_nxt   = dv[cfr_pkg::DIV_BITS];
    za_nxt.z = zc;
  end

  always_comb begin
    zabs = za_r.z[31] ? 31'(-za_r.z) : za_r.z[30:0];
    zb_nxt      = za_r;
    zb_nxt.rad  = 61'(62'(1) << 60) - 61'(62'(zabs) * 62'(zabs));
    zb_nxt.root = '0;
  end

  assign sq[0] = zb_r;

  for (genvar g = 0; g < cfr_pkg::SQRT_BITS; g++) begin : g_sqrt
    cfr_sqrt_cell #(.M(cfr_pkg::SQRT_BITS - 1 - g)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .a_in  (sq[g]),
      .a_out (sq[g+1])
    );
  end

  always_comb begin
    prod_x = $signed({1'b0, sq[cfr_pkg::SQRT_BITS].root[30:0]}) * sq[cfr_pkg::SQRT_BITS].cs;
    prod_y = $signed({1'b0, sq[cfr_pkg::SQRT_BITS].root[30:0]}) * sq[cfr_pkg::SQRT_BITS].sn;
    mu_nxt    = sq[cfr_pkg::SQRT_BITS];
    mu_nxt.px = prod_x[63:0];
    mu_nxt.py = prod_y[63:0];
  end

  always_comb begin
    rx = (mu_r.px + 64'sd17592186044416) >>> 45;
    ry = (mu_r.py + 64'sd17592186044416) >>> 45;
    rz = ($signed(64'(mu_r.z)) + 64'sd16384) >>> 15;
    ox = sat16(rx);
    oy = sat16(ry);
    oz = sat16(rz);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r.vld    <= 1'b0;
      p1_r.vld    <= 1'b0;
      q_r.vld     <= 1'b0;
      m1_r.vld    <= 1'b0;
      za_r.vld    <= 1'b0;
      zb_r.vld    <= 1'b0;
      mu_r.vld    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s0_r        <= s0_nxt;
      p1_r        <= p1_nxt;
      q_r         <= q_nxt;
      m1_r        <= m1_nxt;
      za_r        <= za_nxt;
      zb_r        <= zb_nxt;
      mu_r        <= mu_nxt;
      out_valid_r <= mu_r.vld;
      out_oor_r   <= mu_r.oor;
      out_x_r     <= mu_r.oor ? 16'sd0 : ox;
      out_y_r     <= mu_r.oor ? 16'sd0 : oy;
      out_z_r     <= mu_r.oor ? 16'sd0 : oz;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_dir_x              = out_x_r;
  assign out_dir_y              = out_y_r;
  assign out_dir_z              = out_z_r;
  assign out_index_out_of_range = out_oor_r;

endmodule
